/* src/mgt_pkg.sv */
// ============================================================================
// mgt_pkg
// Shared types and constants of the masked grid triangulator.
// ============================================================================
package mgt_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int IDX_W      = 21;
    localparam int OUT_IDX_W  = 20;
    localparam int COORD_W    = 10;
    localparam int DEPTH_W    = 32;
    localparam int NORM_W     = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [IDX_W-1:0] IDX_NONE = 21'h1FFFFF;
    localparam logic [IDX_W-1:0] IDX_TOP  = 21'h1FFFFE;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                     mask;
        logic [IDX_W-1:0]         cur;
        logic                     row_end;
        logic                     has_above;
        logic                     has_window;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic [DEPTH_W-1:0]       depth;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } pix_t;

    typedef struct packed {
        logic                     have_v;
        logic                     have_t1;
        logic                     have_t2;
        logic [OUT_IDX_W-1:0]     v_idx;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic [DEPTH_W-1:0]       depth;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [OUT_IDX_W-1:0]     t1_a;
        logic [OUT_IDX_W-1:0]     t1_b;
        logic [OUT_IDX_W-1:0]     t1_c;
        logic [OUT_IDX_W-1:0]     t2_a;
        logic [OUT_IDX_W-1:0]     t2_b;
        logic [OUT_IDX_W-1:0]     t2_c;
    } rec_set_t;

endpackage

/* src/mgt_if.sv */
// ============================================================================
// mgt_if
// Channel interfaces: pixel input, record output and register writes.
// ============================================================================
interface mgt_pix_if;
    import mgt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mask_bit;
    logic [DEPTH_W-1:0]       depth_value;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;

    modport source (
        output valid, mask_bit, depth_value, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, mask_bit, depth_value, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface mgt_rec_if;
    import mgt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     record_kind;
    logic [OUT_IDX_W-1:0]     index_a;
    logic [OUT_IDX_W-1:0]     index_b;
    logic [OUT_IDX_W-1:0]     index_c;
    logic [COORD_W-1:0]       pixel_col;
    logic [COORD_W-1:0]       pixel_row;
    logic [DEPTH_W-1:0]       vertex_depth;
    logic signed [NORM_W-1:0] vertex_nx;
    logic signed [NORM_W-1:0] vertex_ny;
    logic signed [NORM_W-1:0] vertex_nz;
    logic                     last_of_pixel;

    modport source (
        output valid, record_kind, index_a, index_b, index_c, pixel_col, pixel_row,
               vertex_depth, vertex_nx, vertex_ny, vertex_nz, last_of_pixel,
        input  ready
    );
    modport sink (
        input  valid, record_kind, index_a, index_b, index_c, pixel_col, pixel_row,
               vertex_depth, vertex_nx, vertex_ny, vertex_nz, last_of_pixel,
        output ready
    );
endinterface

interface mgt_cfg_if;
    import mgt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* src/mgt_front.sv */
// ============================================================================
// mgt_front
// Pixel intake: frame geometry registers, column/row/vertex counters.
// ============================================================================
module mgt_front #(
    parameter int MAX_WIDTH  = mgt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mgt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mgt_pix_if.sink                      in_ch,
    mgt_cfg_if.sink                      cfg_ch,
    input  logic                         s0_ready,
    output logic                         s0_valid,
    output logic [$clog2(MAX_WIDTH)-1:0] s0_col,
    output mgt_pkg::pix_t                s0_pix,
    output logic                         restart
);
    import mgt_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int RST_H = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

    logic [DW-1:0]    width_reg, width_next;
    logic [HW-1:0]    height_reg, height_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [IDX_W-1:0] vcount_reg, vcount_next;
    logic             accept;
    logic             cfg_wr;
    logic             col_wrap;
    logic             row_wrap;
    logic [IDX_W-1:0] vcount_step;

    assign in_ch.ready  = s0_ready;
    assign s0_valid     = in_ch.valid;
    assign accept       = in_ch.valid && s0_ready;
    assign cfg_ch.ready = 1'b1;
    assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_wr)
        begin
            case (cfg_ch.index)
                REG_IMAGE_WIDTH:
                begin
                    restart = 1'b1;
                    if (cfg_ch.data < 11'd2)
                        width_next = DW'(2);
                    else if (32'(cfg_ch.data) > 32'(MAX_WIDTH))
                        width_next = DW'(MAX_WIDTH);
                    else
                        width_next = DW'(cfg_ch.data);
                end
                REG_IMAGE_HEIGHT:
                begin
                    restart = 1'b1;
                    if (cfg_ch.data < 11'd2)
                        height_next = HW'(2);
                    else if (32'(cfg_ch.data) > 32'(MAX_HEIGHT))
                        height_next = HW'(MAX_HEIGHT);
                    else
                        height_next = HW'(cfg_ch.data);
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        col_wrap    = (32'(col_reg) + 32'd1) >= 32'(width_reg);
        row_wrap    = (32'(row_reg) + 32'd1) >= 32'(height_reg);
        vcount_step = (in_ch.mask_bit && (vcount_reg < IDX_TOP)) ?
                      vcount_reg + IDX_W'(1) : vcount_reg;

        s0_col            = col_reg;
        s0_pix.mask       = in_ch.mask_bit;
        s0_pix.cur        = in_ch.mask_bit ? vcount_reg : IDX_NONE;
        s0_pix.row_end    = col_wrap;
        s0_pix.has_above  = (row_reg != '0);
        s0_pix.has_window = (row_reg != '0) && (col_reg != '0);
        s0_pix.col        = COORD_W'(col_reg);
        s0_pix.row        = COORD_W'(row_reg);
        s0_pix.depth      = in_ch.depth_value;
        s0_pix.nx         = in_ch.normal_x;
        s0_pix.ny         = in_ch.normal_y;
        s0_pix.nz         = in_ch.normal_z;

        col_next    = col_reg;
        row_next    = row_reg;
        vcount_next = vcount_reg;
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            vcount_next = '0;
        end
        else if (accept)
        begin
            vcount_next = vcount_step;
            if (col_wrap)
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    row_next    = '0;
                    vcount_next = '0;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(RST_W);
            height_reg <= HW'(RST_H);
            col_reg    <= '0;
            row_reg    <= '0;
            vcount_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            vcount_reg <= vcount_next;
        end
    end

endmodule

/* src/mgt_window.sv */
// ============================================================================
// mgt_window
// Row-above index memory and 2x2 window stage that forms the triangles.
// ============================================================================
module mgt_window #(
    parameter int MAX_WIDTH = mgt_pkg::DEF_MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic                         s0_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] s0_col,
    input  mgt_pkg::pix_t                s0_pix,
    output logic                         s0_ready,
    output logic                         set_valid,
    output mgt_pkg::rec_set_t            set,
    input  logic                         set_ready
);
    import mgt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [IDX_W-1:0] mem [MAX_WIDTH];
    logic [IDX_W-1:0] rdata_reg;
    logic             s1_valid_reg, s1_valid_next;
    pix_t             s1_reg;
    logic [CW-1:0]    col1_reg;
    logic [IDX_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0] ul_reg, ul_next;
    logic             accept;
    logic             s1_move;
    logic [IDX_W-1:0] above;
    logic             v_ul, v_l, v_c, v_a;
    logic [IDX_W-1:0] ta, tb, tc;
    logic             tri_one, tri_two;

    assign s1_move  = s1_valid_reg && set_ready;
    assign s0_ready = !s1_valid_reg || set_ready;
    assign accept   = s0_valid && s0_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[s0_col];
            s1_reg    <= s0_pix;
            col1_reg  <= s0_col;
        end
        if (s1_move)
        begin
            mem[col1_reg] <= s1_reg.cur;
        end
    end

    always_comb
    begin
        above = s1_reg.has_above ? rdata_reg : IDX_NONE;
        v_ul  = (ul_reg != IDX_NONE);
        v_l   = (left_reg != IDX_NONE);
        v_c   = (s1_reg.cur != IDX_NONE);
        v_a   = (above != IDX_NONE);

        ta = ul_reg;
        tb = left_reg;
        tc = s1_reg.cur;
        if (!v_ul)
        begin
            ta = left_reg;
            tb = s1_reg.cur;
            tc = above;
        end
        else if (!v_l)
        begin
            tb = s1_reg.cur;
            tc = above;
        end
        else if (!v_c)
        begin
            tc = above;
        end

        tri_two = s1_reg.has_window && v_ul && v_l && v_c && v_a;
        tri_one = s1_reg.has_window &&
                  (32'(v_ul) + 32'(v_l) + 32'(v_c) + 32'(v_a) >= 32'd3);

        set.have_v  = s1_reg.mask;
        set.have_t1 = tri_one;
        set.have_t2 = tri_two;
        set.v_idx   = OUT_IDX_W'(s1_reg.cur);
        set.col     = s1_reg.col;
        set.row     = s1_reg.row;
        set.depth   = s1_reg.depth;
        set.nx      = s1_reg.nx;
        set.ny      = s1_reg.ny;
        set.nz      = s1_reg.nz;
        set.t1_a    = OUT_IDX_W'(ta);
        set.t1_b    = OUT_IDX_W'(tb);
        set.t1_c    = OUT_IDX_W'(tc);
        set.t2_a    = OUT_IDX_W'(ul_reg);
        set.t2_b    = OUT_IDX_W'(s1_reg.cur);
        set.t2_c    = OUT_IDX_W'(above);
        set_valid   = s1_valid_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        left_next     = left_reg;
        ul_next       = ul_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        if (restart)
        begin
            left_next = IDX_NONE;
            ul_next   = IDX_NONE;
        end
        else if (s1_move)
        begin
            left_next = s1_reg.row_end ? IDX_NONE : s1_reg.cur;
            ul_next   = s1_reg.row_end ? IDX_NONE : above;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            left_reg     <= IDX_NONE;
            ul_reg       <= IDX_NONE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            left_reg     <= left_next;
            ul_reg       <= ul_next;
        end
    end

endmodule

/* src/mgt_emit.sv */
// ============================================================================
// mgt_emit
// Output register: a pixel's vertex and triangles, one per cycle while ready.
// ============================================================================
module mgt_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              set_valid,
    input  mgt_pkg::rec_set_t set,
    output logic              set_ready,
    mgt_rec_if.source         out_ch
);
    import mgt_pkg::*;

    rec_set_t   buf_reg;
    logic [2:0] pending_reg, pending_next;
    logic [2:0] pending_rest;
    logic       single;
    logic       out_fire;
    logic       load;

    assign pending_rest = pending_reg & (pending_reg - 3'd1);
    assign single       = (pending_reg != 3'd0) && (pending_rest == 3'd0);
    assign out_fire     = out_ch.valid && out_ch.ready;
    assign set_ready    = (pending_reg == 3'd0) || (single && out_ch.ready);
    assign load         = set_valid && set_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (load)
            pending_next = {set.have_t2, set.have_t1, set.have_v};
        else if (out_fire)
            pending_next = pending_rest;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_next;
    end

    always_comb
    begin
        out_ch.valid         = (pending_reg != 3'd0);
        out_ch.last_of_pixel = single;
        out_ch.record_kind   = KIND_TRIANGLE;
        out_ch.index_a       = buf_reg.t2_a;
        out_ch.index_b       = buf_reg.t2_b;
        out_ch.index_c       = buf_reg.t2_c;
        out_ch.pixel_col     = '0;
        out_ch.pixel_row     = '0;
        out_ch.vertex_depth  = '0;
        out_ch.vertex_nx     = '0;
        out_ch.vertex_ny     = '0;
        out_ch.vertex_nz     = '0;
        if (pending_reg[0])
        begin
            out_ch.record_kind  = KIND_VERTEX;
            out_ch.index_a      = buf_reg.v_idx;
            out_ch.index_b      = '0;
            out_ch.index_c      = '0;
            out_ch.pixel_col    = buf_reg.col;
            out_ch.pixel_row    = buf_reg.row;
            out_ch.vertex_depth = buf_reg.depth;
            out_ch.vertex_nx    = buf_reg.nx;
            out_ch.vertex_ny    = buf_reg.ny;
            out_ch.vertex_nz    = buf_reg.nz;
        end
        else if (pending_reg[1])
        begin
            out_ch.index_a = buf_reg.t1_a;
            out_ch.index_b = buf_reg.t1_b;
            out_ch.index_c = buf_reg.t1_c;
        end
    end

endmodule

/* src/masked_grid_triangulator_top.sv */
// ============================================================================
// masked_grid_triangulator_top
// A pixel passes the window stage register, then the output register.
// Throughput: one result per cycle while out_ch.ready; up to three per pixel,
// sent in turn by the single output register. Reset: counters clear, left
// indices go invalid, width/height return to min(256, MAX_WIDTH/MAX_HEIGHT).
// The row-above index memory is not cleared; row 0 of every frame fills it.
// ============================================================================
module masked_grid_triangulator_top #(
    parameter int MAX_WIDTH  = mgt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mgt_pkg::DEF_MAX_HEIGHT
) (
    input  logic      clk,
    input  logic      rst_n,
    mgt_pix_if.sink   in_ch,
    mgt_rec_if.source out_ch,
    mgt_cfg_if.sink   cfg_ch
);
    import mgt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          s0_valid;
    logic          s0_ready;
    logic [CW-1:0] s0_col;
    pix_t          s0_pix;
    logic          restart;
    logic          set_valid;
    logic          set_ready;
    rec_set_t      set;

    mgt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg_ch   (cfg_ch),
        .s0_ready (s0_ready),
        .s0_valid (s0_valid),
        .s0_col   (s0_col),
        .s0_pix   (s0_pix),
        .restart  (restart)
    );

    mgt_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .s0_valid  (s0_valid),
        .s0_col    (s0_col),
        .s0_pix    (s0_pix),
        .s0_ready  (s0_ready),
        .set_valid (set_valid),
        .set       (set),
        .set_ready (set_ready)
    );

    mgt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_valid (set_valid),
        .set       (set),
        .set_ready (set_ready),
        .out_ch    (out_ch)
    );

endmodule
